@@ src/upe_pkg.sv @@
// URL percent encoder package: payload structs, phase codes, character constants.
// Holds the byte classification and hex digit helpers. No dependencies.
package upe_pkg;

  typedef enum logic [2:0] {
    PH_SCHEME = 3'd0,
    PH_SLASH1 = 3'd1,
    PH_HOST   = 3'd2,
    PH_PATH   = 3'd3,
    PH_QUERY  = 3'd4,
    PH_FRAG   = 3'd5
  } phase_t;

  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3D;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_DASH    = 8'h2D;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       string_done;
  } out_t;

  // Front register contents handed to the serializer.
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
    logic       escape;
  } front_t;

  function automatic logic is_unreserved(input logic [7:0] b);
    logic res;
    res = (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
          (b >= 8'h30 && b <= 8'h39) ||
          b == CH_DASH || b == CH_UNDER || b == CH_DOT || b == CH_TILDE;
    return res;
  endfunction

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    logic [7:0] res;
    if (n < 4'd10) begin
      res = 8'h30 + {4'd0, n};
    end else begin
      res = 8'h37 + {4'd0, n};
    end
    return res;
  endfunction

endpackage

@@ src/url_percent_encoder.sv @@
// URL percent encoder top level: input stage feeding the output serializer.
// Depends on upe_pkg, upe_front, upe_serial.
//
// Usage:
//   item channel (item_valid/item_ready/item): one raw URL byte per beat,
//   with end_of_string set on the final byte of a URL.
//   res channel (res_valid/res_ready/res): one encoded byte per beat.
//   Each input byte yields one beat, or three ('%' and two uppercase hex
//   digits) when escaped; last_of_run marks the final beat of an input,
//   string_done the final beat of a URL.
// Path: an accepted input beat moves through the input register into the result register.
// Throughput: one result beat per cycle while res_ready is high; the output
//   serializer sets this.
// Reset: rst (synchronous) empties both registers and returns the phase
//   tracker to the scheme phase.
// Stall: while res_ready is low the result beat holds; one further input
//   beat is buffered in the input register, then item_ready drops.
module url_percent_encoder (
  input  logic           clk,
  input  logic           rst,
  input  logic           item_valid,
  output logic           item_ready,
  input  upe_pkg::in_t   item,
  output logic           res_valid,
  input  logic           res_ready,
  output upe_pkg::out_t  res
);

  logic            f_valid;
  logic            f_take;
  upe_pkg::front_t f_data;

  upe_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .f_valid    (f_valid),
    .f_take     (f_take),
    .f_data     (f_data)
  );

  upe_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .f_valid   (f_valid),
    .f_take    (f_take),
    .f_data    (f_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

endmodule

@@ src/upe_front.sv @@
// Input stage: phase tracker and input register with the escape decision.
// Depends on upe_pkg.
module upe_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  upe_pkg::in_t     item,
  output logic             f_valid,
  input  logic             f_take,
  output upe_pkg::front_t  f_data
);

  upe_pkg::phase_t phase, phase_next;
  logic            fv;
  logic            accept;
  logic            escape;
  logic            unres;
  logic [7:0]      b;

  assign b          = item.in_byte;
  assign item_ready = !fv || f_take;
  assign accept     = item_valid && item_ready;
  assign f_valid    = fv;
  assign unres      = upe_pkg::is_unreserved(b);

  always_comb begin
    phase_next = phase;
    unique case (phase)
      upe_pkg::PH_SLASH1: if (b == upe_pkg::CH_SLASH) phase_next = upe_pkg::PH_HOST;
      upe_pkg::PH_HOST:   if (b == upe_pkg::CH_SLASH) phase_next = upe_pkg::PH_PATH;
      upe_pkg::PH_PATH:   if (b == upe_pkg::CH_QUEST) phase_next = upe_pkg::PH_QUERY;
      upe_pkg::PH_QUERY:  if (b == upe_pkg::CH_HASH) phase_next = upe_pkg::PH_FRAG;
      upe_pkg::PH_FRAG:   phase_next = upe_pkg::PH_FRAG;
      default: begin
        if (b == upe_pkg::CH_SLASH) phase_next = upe_pkg::PH_SLASH1;
        else phase_next = upe_pkg::PH_SCHEME;
      end
    endcase
    if (item.end_of_string) phase_next = upe_pkg::PH_SCHEME;
  end

  always_comb begin
    unique case (phase)
      upe_pkg::PH_PATH:
        escape = !unres && b != upe_pkg::CH_SLASH && b != upe_pkg::CH_QUEST;
      upe_pkg::PH_QUERY:
        escape = !unres && b != upe_pkg::CH_AMP && b != upe_pkg::CH_EQUAL &&
                 b != upe_pkg::CH_HASH;
      upe_pkg::PH_FRAG:
        escape = !unres;
      default:
        escape = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fv    <= 1'b0;
      phase <= upe_pkg::PH_SCHEME;
    end else if (accept) begin
      fv    <= 1'b1;
      phase <= phase_next;
    end else if (f_take) begin
      fv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data.data   <= b;
      f_data.eos    <= item.end_of_string;
      f_data.escape <= escape;
    end
  end

endmodule

@@ src/upe_serial.sv @@
// Output stage: result register that emits one byte, or '%' and two hex digits.
// Depends on upe_pkg.
module upe_serial (
  input  logic             clk,
  input  logic             rst,
  input  logic             f_valid,
  output logic             f_take,
  input  upe_pkg::front_t  f_data,
  output logic             res_valid,
  input  logic             res_ready,
  output upe_pkg::out_t    res
);

  logic       rv;
  logic [1:0] pos;
  logic [7:0] data;
  logic       eos;
  logic       escape;
  logic       last_now;

  assign last_now  = !escape || pos == 2'd2;
  assign f_take    = f_valid && (!rv || (res_ready && last_now));
  assign res_valid = rv;

  always_comb begin
    unique case (pos)
      2'd0:    res.out_byte = escape ? upe_pkg::CH_PERCENT : data;
      2'd1:    res.out_byte = upe_pkg::hex_digit(data[7:4]);
      default: res.out_byte = upe_pkg::hex_digit(data[3:0]);
    endcase
    res.last_of_run = last_now;
    res.string_done = last_now && eos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv  <= 1'b0;
      pos <= 2'd0;
    end else if (f_take) begin
      rv  <= 1'b1;
      pos <= 2'd0;
    end else if (rv && res_ready) begin
      if (last_now) rv <= 1'b0;
      else pos <= pos + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (f_take) begin
      data   <= f_data.data;
      eos    <= f_data.eos;
      escape <= f_data.escape;
    end
  end

endmodule
